@@ src/sjfba_pkg.sv @@
// shared types, codes and defaults of the shortest-job-first burst-average scheduler
// no dependencies; every other file of the block but sjfba_ram refers to this package by scoped names
package sjfba_pkg;

    localparam int DEF_NUM_SLOTS = 64;
    localparam int DEF_MEAN_BITS = 16;

    localparam int FUNC_BITS  = 3;
    localparam int SLOT_FIELD = 6;
    localparam int BURST_BITS = 16;
    localparam int TICK_BITS  = 32;
    localparam int MEAN_FIELD = 16;
    localparam int STAT_BITS  = 2;
    localparam int RATE_BITS  = 4;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 32;

    localparam int QUEUE_DEPTH = 2;

    // input function codes
    localparam logic [FUNC_BITS-1:0] FUNC_ALLOC    = 3'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_RUN      = 3'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_STOP     = 3'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_DISPATCH = 3'd3;
    localparam logic [FUNC_BITS-1:0] FUNC_BURST    = 3'd4;

    // result status codes
    localparam logic [STAT_BITS-1:0] STATUS_DONE   = 2'd0;
    localparam logic [STAT_BITS-1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [STAT_BITS-1:0] STATUS_PAUSED = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_RATE  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PAUSE = 1'd1;

    localparam logic [RATE_BITS-1:0] RATE_RESET  = 4'd5;
    localparam logic [TICK_BITS-1:0] PAUSE_RESET = 32'd0;
    localparam logic [RATE_BITS-1:0] RATE_FULL   = 4'd10;
    localparam logic [4:0]           DIVISOR     = 5'd10;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ALLOC,
        OP_RUN,
        OP_STOP,
        OP_DISPATCH,
        OP_BURST
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [SLOT_FIELD-1:0] slot;
        logic                  prot;
        logic [BURST_BITS-1:0] burst;
        logic                  paused;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } link_t;

    typedef struct packed {
        logic                  grant_valid;
        logic [SLOT_FIELD-1:0] grant_slot;
        logic [MEAN_FIELD-1:0] mean_value;
        logic [STAT_BITS-1:0]  status;
    } res_t;

endpackage

@@ src/sjfba_cmd_if.sv @@
// input channel of the scheduler: valid/ready plus the fields of one item
// depends on sjfba_pkg for field widths
interface sjfba_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [sjfba_pkg::FUNC_BITS-1:0]  func;
    logic [sjfba_pkg::SLOT_FIELD-1:0] slot;
    logic                             protected_flag;
    logic [sjfba_pkg::BURST_BITS-1:0] burst_ticks;
    logic [sjfba_pkg::TICK_BITS-1:0]  now_tick;

    modport source (output valid, func, slot, protected_flag, burst_ticks, now_tick,
                    input ready);
    modport sink (input valid, func, slot, protected_flag, burst_ticks, now_tick,
                  output ready);
endinterface

@@ src/sjfba_res_if.sv @@
// result channel of the scheduler: valid/ready plus the fields of one result
// depends on sjfba_pkg for field widths
interface sjfba_res_if;
    logic                             valid;
    logic                             ready;
    logic                             grant_valid;
    logic [sjfba_pkg::SLOT_FIELD-1:0] grant_slot;
    logic [sjfba_pkg::MEAN_FIELD-1:0] mean_value;
    logic [sjfba_pkg::STAT_BITS-1:0]  status;

    modport source (output valid, grant_valid, grant_slot, mean_value, status,
                    input ready);
    modport sink (input valid, grant_valid, grant_slot, mean_value, status,
                  output ready);
endinterface

@@ src/sjf_burst_average_scheduler_core.sv @@
// Shortest-job-first dispatcher over a table of NUM_SLOTS slots, each keeping a runnable
// mark, a protected mark and an exponential mean of its burst lengths. The front end
// accepts one item per cycle while its two-entry command queue has room; the back end
// executes one command at a time and takes the next one from the queue only once the
// pending result has transferred, at the earliest in the cycle after. Allocate, run, stop
// and ignored items execute as they leave the queue and register their result. A dispatch
// leaves the queue, scans the mean table, a ram read one entry per cycle through its read
// port, then drains the last read and decides. A burst report leaves the queue with the
// table read, then forms the weighted products, the sum, and a registered reciprocal divide
// by ten. Table entries carry valid flops cleared by reset, so no clearing pass runs after
// reset. Configuration writes (index 0 rate in tenths, index 1 pause limit) are taken at any
// cycle with cfg_we high; the pause limit is compared when an item is accepted and the rate
// is used when a burst report executes, so write them only while no item is in flight.
// depends on sjfba_pkg, the channel interfaces, sjfba_front and sjfba_back
module sjf_burst_average_scheduler_core #(
    parameter int NUM_SLOTS = sjfba_pkg::DEF_NUM_SLOTS,
    parameter int MEAN_BITS = sjfba_pkg::DEF_MEAN_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    sjfba_cmd_if.sink                           cmd,
    sjfba_res_if.source                         res,
    input  logic                                cfg_we,
    input  logic [sjfba_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [sjfba_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    logic [sjfba_pkg::RATE_BITS-1:0] rate_reg;
    logic [sjfba_pkg::TICK_BITS-1:0] pause_reg;
    sjfba_pkg::link_t                link;
    logic                            pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= sjfba_pkg::RATE_RESET;
            pause_reg <= sjfba_pkg::PAUSE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sjfba_pkg::CFG_RATE:  rate_reg  <= cfg_data[sjfba_pkg::RATE_BITS-1:0];
                sjfba_pkg::CFG_PAUSE: pause_reg <= cfg_data[sjfba_pkg::TICK_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    sjfba_front #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .pause_until(pause_reg),
        .link       (link),
        .pop        (pop)
    );

    sjfba_back #(
        .NUM_SLOTS(NUM_SLOTS),
        .MEAN_BITS(MEAN_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .link       (link),
        .pop        (pop),
        .rate_tenths(rate_reg),
        .res        (res)
    );

endmodule

@@ src/sjfba_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module sjfba_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

@@ src/sjfba_div10.sv @@
// divide by ten as a multiply by a scaled reciprocal; start is registered, then done
// depends on sjfba_pkg for the divisor
module sjfba_div10 #(
    parameter int W = 20
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    output logic         done,
    output logic [W-1:0] quotient
);

    // reciprocal scaled by 2^(W+4) and rounded up, exact for every W-bit dividend
    localparam int              SHIFT    = W + 4;
    localparam longint unsigned DIV_64   = 64'(sjfba_pkg::DIVISOR);
    localparam longint unsigned RECIP_64 = ((64'd1 << SHIFT) + DIV_64 - 64'd1) / DIV_64;
    localparam logic [W:0]      RECIP    = (W + 1)'(RECIP_64);

    logic           stage_reg;
    logic           done_reg;
    logic [W-1:0]   x_reg;
    logic [W-1:0]   q_reg;
    logic [2*W:0]   product;

    assign product  = {{(W + 1){1'b0}}, x_reg} * {{W{1'b0}}, RECIP};
    assign done     = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= start;
            done_reg  <= stage_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= dividend;
        end
        if (stage_reg)
        begin
            q_reg <= {3'b000, product[2*W:SHIFT]};
        end
    end

endmodule

@@ src/sjfba_front.sv @@
// front end: accepts items, decodes them into commands and queues them for the back end
// depends on sjfba_pkg and sjfba_cmd_if
module sjfba_front #(
    parameter int NUM_SLOTS = sjfba_pkg::DEF_NUM_SLOTS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    sjfba_cmd_if.sink                       cmd,
    input  logic [sjfba_pkg::TICK_BITS-1:0] pause_until,
    output sjfba_pkg::link_t                link,
    input  logic                            pop
);

    localparam int PTR_BITS = (sjfba_pkg::QUEUE_DEPTH > 1) ? $clog2(sjfba_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(sjfba_pkg::QUEUE_DEPTH + 1);

    sjfba_pkg::cmd_t     q_mem_reg [sjfba_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    sjfba_pkg::cmd_t     decoded;
    logic                push;
    logic                take;
    logic                out_of_table;

    // decode one item into a command
    always_comb
    begin
        out_of_table   = int'(cmd.slot) >= NUM_SLOTS;
        decoded.slot   = cmd.slot;
        decoded.prot   = cmd.protected_flag;
        decoded.burst  = cmd.burst_ticks;
        decoded.paused = cmd.now_tick < pause_until;
        decoded.op     = sjfba_pkg::OP_NOP;
        if (cmd.func == sjfba_pkg::FUNC_DISPATCH)
        begin
            decoded.op = sjfba_pkg::OP_DISPATCH;
        end
        else if (!out_of_table)
        begin
            unique case (cmd.func)
                sjfba_pkg::FUNC_ALLOC: decoded.op = sjfba_pkg::OP_ALLOC;
                sjfba_pkg::FUNC_RUN:   decoded.op = sjfba_pkg::OP_RUN;
                sjfba_pkg::FUNC_STOP:  decoded.op = sjfba_pkg::OP_STOP;
                sjfba_pkg::FUNC_BURST: decoded.op = sjfba_pkg::OP_BURST;
                default:               decoded.op = sjfba_pkg::OP_NOP;
            endcase
        end
    end

    assign cmd.ready  = count_reg != CNT_BITS'(sjfba_pkg::QUEUE_DEPTH);
    assign push       = cmd.valid && cmd.ready;
    assign link.valid = count_reg != '0;
    assign link.cmd   = q_mem_reg[rd_ptr_reg];
    assign take       = link.valid && pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(sjfba_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (take)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(sjfba_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !take)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (take && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

@@ src/sjfba_back.sv @@
// back end: executes queued commands against the slot table and holds the result register
// depends on sjfba_pkg, sjfba_res_if, sjfba_ram and sjfba_div10
module sjfba_back #(
    parameter int NUM_SLOTS = sjfba_pkg::DEF_NUM_SLOTS,
    parameter int MEAN_BITS = sjfba_pkg::DEF_MEAN_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sjfba_pkg::link_t                link,
    output logic                            pop,
    input  logic [sjfba_pkg::RATE_BITS-1:0] rate_tenths,
    sjfba_res_if.source                     res
);

    localparam int SLOT_BITS = $clog2(NUM_SLOTS);
    localparam int CNT_BITS  = $clog2(NUM_SLOTS + 1);
    localparam int WORD_BITS = MEAN_BITS + 1;
    localparam int SUM_BITS  = MEAN_BITS + 4;
    localparam int SF        = sjfba_pkg::SLOT_FIELD;
    localparam int MF        = sjfba_pkg::MEAN_FIELD;
    localparam int BB        = sjfba_pkg::BURST_BITS;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_DECIDE = 6'b000100,
        ST_MUL    = 6'b001000,
        ST_SUM    = 6'b010000,
        ST_DIV    = 6'b100000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    sjfba_pkg::cmd_t      cmd_reg;
    logic [NUM_SLOTS-1:0] runnable_reg;
    logic [NUM_SLOTS-1:0] entry_valid_reg;
    logic                 rd_valid_reg;
    logic [CNT_BITS-1:0]  scan_cnt_reg;
    logic                 pend_reg;
    logic [SLOT_BITS-1:0] pend_idx_reg;
    logic                 found_reg;
    logic [SLOT_BITS-1:0] best_idx_reg;
    logic [MEAN_BITS-1:0] best_mean_reg;
    logic                 best_prot_reg;
    logic [SUM_BITS-1:0]  prod_a_reg;
    logic [SUM_BITS-1:0]  prod_b_reg;
    logic                 old_prot_reg;
    logic                 out_valid_reg;
    sjfba_pkg::res_t      res_reg;

    logic [SLOT_BITS+SF-1:0]   head_w;
    logic [SLOT_BITS+SF-1:0]   cur_w;
    logic [SLOT_BITS-1:0]      head_idx;
    logic [SLOT_BITS-1:0]      cur_idx;
    logic [SLOT_BITS-1:0]      rd_addr;
    logic [WORD_BITS-1:0]      rd_data;
    logic [WORD_BITS-1:0]      entry_word;
    logic [MEAN_BITS-1:0]      ent_mean;
    logic                      ent_prot;
    logic                      we;
    logic [SLOT_BITS-1:0]      waddr;
    logic [WORD_BITS-1:0]      wdata;
    logic                      issue;
    logic                      take;
    logic                      scan_done;
    logic                      grant_ok;
    logic [sjfba_pkg::RATE_BITS-1:0] r_eff;
    logic [sjfba_pkg::RATE_BITS-1:0] w_old;
    logic [MEAN_BITS+BB-1:0]   burst_w;
    logic [MEAN_BITS-1:0]      b_sat;
    logic [SUM_BITS-1:0]       prod_a_next;
    logic [SUM_BITS-1:0]       prod_b_next;
    logic                      div_start;
    logic [SUM_BITS-1:0]       dividend;
    logic                      div_done;
    logic [SUM_BITS-1:0]       quotient;
    logic [MEAN_BITS-1:0]      new_mean;
    logic [MEAN_BITS+MF-1:0]   best_mean_w;
    logic [MEAN_BITS+MF-1:0]   new_mean_w;
    logic [SLOT_BITS+SF-1:0]   grant_w;

    assign head_w   = {{SLOT_BITS{1'b0}}, link.cmd.slot};
    assign cur_w    = {{SLOT_BITS{1'b0}}, cmd_reg.slot};
    assign head_idx = head_w[SLOT_BITS-1:0];
    assign cur_idx  = cur_w[SLOT_BITS-1:0];

    assign pop = (state_reg == ST_IDLE) && link.valid && !out_valid_reg;

    // scan issues one read a cycle and compares the entry read the cycle before
    assign issue     = (state_reg == ST_SCAN) && (scan_cnt_reg < CNT_BITS'(NUM_SLOTS));
    assign rd_addr   = (state_reg == ST_SCAN) ? scan_cnt_reg[SLOT_BITS-1:0] : head_idx;
    // an entry never written reads as cleared
    assign entry_word = rd_valid_reg ? rd_data : '0;
    assign ent_mean   = entry_word[MEAN_BITS-1:0];
    assign ent_prot   = entry_word[MEAN_BITS];
    assign take       = pend_reg && runnable_reg[pend_idx_reg] &&
                        (!found_reg || (ent_mean < best_mean_reg));
    assign scan_done  = (state_reg == ST_SCAN) && !issue && !pend_reg;
    assign grant_ok   = found_reg && !(cmd_reg.paused && !best_prot_reg);

    // weighted average terms
    assign r_eff   = (rate_tenths > sjfba_pkg::RATE_FULL) ? sjfba_pkg::RATE_FULL : rate_tenths;
    assign w_old   = sjfba_pkg::RATE_FULL - r_eff;
    assign burst_w = {{MEAN_BITS{1'b0}}, cmd_reg.burst};
    assign b_sat   = (burst_w > {{BB{1'b0}}, {MEAN_BITS{1'b1}}}) ?
                     {MEAN_BITS{1'b1}} : burst_w[MEAN_BITS-1:0];
    assign prod_a_next = {{MEAN_BITS{1'b0}}, w_old} * {4'b0, ent_mean};
    assign prod_b_next = {{MEAN_BITS{1'b0}}, r_eff} * {4'b0, b_sat};
    assign div_start   = state_reg == ST_SUM;
    assign dividend    = prod_a_reg + prod_b_reg;
    assign new_mean    = quotient[MEAN_BITS-1:0];

    assign best_mean_w = {{MF{1'b0}}, best_mean_reg};
    assign new_mean_w  = {{MF{1'b0}}, new_mean};
    assign grant_w     = {{SF{1'b0}}, best_idx_reg};

    always_comb
    begin
        we    = 1'b0;
        waddr = head_idx;
        wdata = {link.cmd.prot, {MEAN_BITS{1'b0}}};
        if (pop && (link.cmd.op == sjfba_pkg::OP_ALLOC))
        begin
            we = 1'b1;
        end
        else if ((state_reg == ST_DIV) && div_done)
        begin
            we    = 1'b1;
            waddr = cur_idx;
            wdata = {old_prot_reg, new_mean};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    if (link.cmd.op == sjfba_pkg::OP_DISPATCH)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (link.cmd.op == sjfba_pkg::OP_BURST)
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_SCAN:   state_next = scan_done ? ST_DECIDE : ST_SCAN;
            ST_DECIDE: state_next = ST_IDLE;
            ST_MUL:    state_next = ST_SUM;
            ST_SUM:    state_next = ST_DIV;
            ST_DIV:    state_next = div_done ? ST_IDLE : ST_DIV;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            runnable_reg    <= '0;
            entry_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
            scan_cnt_reg    <= '0;
            pend_reg        <= 1'b0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= entry_valid_reg[rd_addr];
            if (we)
            begin
                entry_valid_reg[waddr] <= 1'b1;
            end
            if (out_valid_reg && res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop)
            begin
                unique case (link.cmd.op)
                    sjfba_pkg::OP_ALLOC:
                    begin
                        runnable_reg[head_idx] <= 1'b0;
                        out_valid_reg          <= 1'b1;
                    end
                    sjfba_pkg::OP_RUN:
                    begin
                        runnable_reg[head_idx] <= 1'b1;
                        out_valid_reg          <= 1'b1;
                    end
                    sjfba_pkg::OP_STOP:
                    begin
                        runnable_reg[head_idx] <= 1'b0;
                        out_valid_reg          <= 1'b1;
                    end
                    sjfba_pkg::OP_DISPATCH:
                    begin
                        scan_cnt_reg <= '0;
                        pend_reg     <= 1'b0;
                        found_reg    <= 1'b0;
                    end
                    sjfba_pkg::OP_BURST:
                    begin
                    end
                    default:
                    begin
                        out_valid_reg <= 1'b1;
                    end
                endcase
            end
            if (state_reg == ST_SCAN)
            begin
                pend_reg <= issue;
                if (issue)
                begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (state_reg == ST_DECIDE)
            begin
                out_valid_reg <= 1'b1;
                if (grant_ok)
                begin
                    runnable_reg[best_idx_reg] <= 1'b0;
                end
            end
            if ((state_reg == ST_DIV) && div_done)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= link.cmd;
            res_reg <= '{grant_valid: 1'b0, grant_slot: '0, mean_value: '0,
                         status: sjfba_pkg::STATUS_DONE};
        end
        if (state_reg == ST_SCAN)
        begin
            pend_idx_reg <= scan_cnt_reg[SLOT_BITS-1:0];
            if (take)
            begin
                best_idx_reg  <= pend_idx_reg;
                best_mean_reg <= ent_mean;
                best_prot_reg <= ent_prot;
            end
        end
        if (state_reg == ST_DECIDE)
        begin
            if (!found_reg)
            begin
                res_reg.status <= sjfba_pkg::STATUS_EMPTY;
            end
            else if (!grant_ok)
            begin
                res_reg.status <= sjfba_pkg::STATUS_PAUSED;
            end
            else
            begin
                res_reg.grant_valid <= 1'b1;
                res_reg.grant_slot  <= grant_w[SF-1:0];
                res_reg.mean_value  <= best_mean_w[MF-1:0];
            end
        end
        if (state_reg == ST_MUL)
        begin
            prod_a_reg   <= prod_a_next;
            prod_b_reg   <= prod_b_next;
            old_prot_reg <= ent_prot;
        end
        if ((state_reg == ST_DIV) && div_done)
        begin
            res_reg.mean_value <= new_mean_w[MF-1:0];
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.grant_valid = res_reg.grant_valid;
    assign res.grant_slot  = res_reg.grant_slot;
    assign res.mean_value  = res_reg.mean_value;
    assign res.status      = res_reg.status;

    sjfba_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(NUM_SLOTS)
    ) u_mean_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    sjfba_div10 #(
        .W(SUM_BITS)
    ) u_div10 (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(dividend),
        .done    (div_done),
        .quotient(quotient)
    );

`ifndef SYNTHESIS
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_cnt_reg <= CNT_BITS'(NUM_SLOTS)))
        else $error("scan counter ran past the table");

    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !out_valid_reg)
        else $error("result pending while a command is executing");

    a_grant_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.grant_valid) |->
        ((res.status == sjfba_pkg::STATUS_DONE) && !runnable_reg[best_idx_reg]))
        else $error("granted slot still runnable");

    a_div_finish: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV) && div_done) |=> ((state_reg == ST_IDLE) && out_valid_reg))
        else $error("burst update did not complete");
`endif

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// regression bench for sjf_burst_average_scheduler_core: directed table, then random phases
// depends on sjf_burst_average_scheduler_core, sjfba_pkg, sjfba_cmd_if and sjfba_res_if from the rtl
module tb;

    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 108;
    // margin past the longest command, a dispatch scan
    localparam int SETTLE_CYCLES   = sjfba_pkg::DEF_NUM_SLOTS + sjfba_pkg::DEF_MEAN_BITS + 8;
    localparam int STALL_LIMIT     = 4000;

    typedef logic [sjfba_pkg::FUNC_BITS-1:0]  func_t;
    typedef logic [sjfba_pkg::SLOT_FIELD-1:0] slot_t;
    typedef logic [sjfba_pkg::BURST_BITS-1:0] burst_t;
    typedef logic [sjfba_pkg::TICK_BITS-1:0]  tick_t;

    localparam func_t  FUNC_UNKNOWN_LO = 3'd5;
    localparam func_t  FUNC_UNKNOWN_HI = 3'd7;
    localparam tick_t  TICK_MAX        = '1;
    localparam burst_t BURST_MAX       = '1;

    typedef struct packed {
        func_t  func;
        slot_t  slot;
        logic   prot;
        burst_t burst;
        tick_t  now;
    } sched_req_t;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_CHECKED,
        ROW_RATE,
        ROW_PAUSE
    } row_kind_t;

    // register rows carry the value to write in the now column
    typedef struct packed {
        row_kind_t         kind;
        sched_req_t        req;
        sjfba_pkg::res_t   exp;
    } step_t;

    localparam int DIRECTED_ROWS = 28;
    localparam step_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_CHECKED, '{sjfba_pkg::FUNC_DISPATCH, 6'd0, 1'b0, 16'd0, 32'd0},
                       '{1'b0, 6'd0, 16'd0, sjfba_pkg::STATUS_EMPTY}},
        '{ROW_CHECKED, '{FUNC_UNKNOWN_LO, 6'd63, 1'b1, BURST_MAX, TICK_MAX},
                       '{1'b0, 6'd0, 16'd0, sjfba_pkg::STATUS_DONE}},
        '{ROW_CHECKED, '{sjfba_pkg::FUNC_ALLOC, 6'd0, 1'b0, 16'd0, 32'd0},
                       '{1'b0, 6'd0, 16'd0, sjfba_pkg::STATUS_DONE}},
        '{ROW_CHECKED, '{sjfba_pkg::FUNC_ALLOC, 6'd63, 1'b1, 16'd0, 32'd0},
                       '{1'b0, 6'd0, 16'd0, sjfba_pkg::STATUS_DONE}},
        '{ROW_CHECKED, '{sjfba_pkg::FUNC_BURST, 6'd0, 1'b0, BURST_MAX, 32'd0},
                       '{1'b0, 6'd0, 16'd32767, sjfba_pkg::STATUS_DONE}},
        '{ROW_CHECKED, '{sjfba_pkg::FUNC_BURST, 6'd63, 1'b0, 16'd0, 32'd0},
                       '{1'b0, 6'd0, 16'd0, sjfba_pkg::STATUS_DONE}},
        '{ROW_ITEM,    '{sjfba_pkg::FUNC_RUN, 6'd0, 1'b0, 16'd0, 32'd0}, '0},
        '{ROW_ITEM,    '{sjfba_pkg::FUNC_RUN, 6'd63, 1'b0, 16'd0, 32'd0}, '0},
        '{ROW_CHECKED, '{sjfba_pkg::FUNC_DISPATCH, 6'd0, 1'b0, 16'd0, 32'd0},
                       '{1'b1, 6'd63, 16'd0, sjfba_pkg::STATUS_DONE}},
        '{ROW_CHECKED, '{sjfba_pkg::FUNC_DISPATCH, 6'd0, 1'b0, 16'd0, 32'd0},
                       '{1'b1, 6'd0, 16'd32767, sjfba_pkg::STATUS_DONE}},
        '{ROW_ITEM,    '{sjfba_pkg::FUNC_RUN, 6'd5, 1'b0, 16'd0, 32'd0}, '0},
        '{ROW_ITEM,    '{sjfba_pkg::FUNC_STOP, 6'd5, 1'b0, 16'd0, 32'd0}, '0},
        '{ROW_CHECKED, '{sjfba_pkg::FUNC_DISPATCH, 6'd0, 1'b0, 16'd0, 32'd0},
                       '{1'b0, 6'd0, 16'd0, sjfba_pkg::STATUS_EMPTY}},
        // equal means: lowest index wins
        '{ROW_ITEM,    '{sjfba_pkg::FUNC_RUN, 6'd10, 1'b0, 16'd0, 32'd0}, '0},
        '{ROW_ITEM,    '{sjfba_pkg::FUNC_RUN, 6'd3, 1'b0, 16'd0, 32'd0}, '0},
        '{ROW_CHECKED, '{sjfba_pkg::FUNC_DISPATCH, 6'd0, 1'b0, 16'd0, 32'd0},
                       '{1'b1, 6'd3, 16'd0, sjfba_pkg::STATUS_DONE}},
        '{ROW_PAUSE,   '{sjfba_pkg::FUNC_ALLOC, 6'd0, 1'b0, 16'd0, TICK_MAX}, '0},
        // tick equal to the limit is not paused
        '{ROW_CHECKED, '{sjfba_pkg::FUNC_DISPATCH, 6'd0, 1'b0, 16'd0, TICK_MAX},
                       '{1'b1, 6'd10, 16'd0, sjfba_pkg::STATUS_DONE}},
        '{ROW_ITEM,    '{sjfba_pkg::FUNC_RUN, 6'd20, 1'b0, 16'd0, 32'd0}, '0},
        '{ROW_ITEM,    '{sjfba_pkg::FUNC_RUN, 6'd63, 1'b0, 16'd0, 32'd0}, '0},
        // unprotected slot 20 wins the tie and blocks the protected one
        '{ROW_CHECKED, '{sjfba_pkg::FUNC_DISPATCH, 6'd0, 1'b0, 16'd0, 32'hFFFF_FFFE},
                       '{1'b0, 6'd0, 16'd0, sjfba_pkg::STATUS_PAUSED}},
        '{ROW_ITEM,    '{sjfba_pkg::FUNC_STOP, 6'd20, 1'b0, 16'd0, 32'd0}, '0},
        '{ROW_CHECKED, '{sjfba_pkg::FUNC_DISPATCH, 6'd0, 1'b0, 16'd0, 32'd0},
                       '{1'b1, 6'd63, 16'd0, sjfba_pkg::STATUS_DONE}},
        // rates above ten act as ten
        '{ROW_RATE,    '{sjfba_pkg::FUNC_ALLOC, 6'd0, 1'b0, 16'd0, 32'd15}, '0},
        '{ROW_CHECKED, '{sjfba_pkg::FUNC_BURST, 6'd0, 1'b0, 16'd100, 32'd0},
                       '{1'b0, 6'd0, 16'd100, sjfba_pkg::STATUS_DONE}},
        '{ROW_RATE,    '{sjfba_pkg::FUNC_ALLOC, 6'd0, 1'b0, 16'd0, 32'd0}, '0},
        '{ROW_CHECKED, '{sjfba_pkg::FUNC_BURST, 6'd0, 1'b0, BURST_MAX, 32'd0},
                       '{1'b0, 6'd0, 16'd100, sjfba_pkg::STATUS_DONE}},
        '{ROW_ITEM,    '{sjfba_pkg::FUNC_BURST, 6'd1, 1'b1, 16'd1234, 32'd7}, '0}
    };

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_we;
    logic [sjfba_pkg::CFG_IDX_BITS-1:0]  cfg_index;
    logic [sjfba_pkg::CFG_DATA_BITS-1:0] cfg_data;
    logic                                take_result = 1'b0;

    int unsigned src_idle = 20;
    int unsigned sink_idle = 70;
    int unsigned idle_cycles = 0;
    int unsigned mismatches = 0;
    int unsigned requests_sent = 0;
    int unsigned grant_count = 0;
    int unsigned paused_count = 0;
    int unsigned empty_count = 0;
    int unsigned burst_count = 0;

    // scheduler state as the bench expects it
    logic                             can_run   [sjfba_pkg::DEF_NUM_SLOTS];
    logic                             shielded  [sjfba_pkg::DEF_NUM_SLOTS];
    logic [sjfba_pkg::MEAN_FIELD-1:0] avg_burst [sjfba_pkg::DEF_NUM_SLOTS];
    logic [sjfba_pkg::RATE_BITS-1:0]  rate_now;
    tick_t                            pause_now;

    sjfba_pkg::res_t awaited_results [$];

    sjfba_cmd_if cmd ();
    sjfba_res_if res ();

    assign res.ready = take_result;

    sjf_burst_average_scheduler_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic sjfba_pkg::res_t sched_outcome(input sched_req_t rq);
        sjfba_pkg::res_t                  r;
        logic                             found;
        int                               best;
        logic [sjfba_pkg::MEAN_FIELD-1:0] best_mean;
        int unsigned                      wt;
        int unsigned                      nm;
        r = '0;
        r.status = sjfba_pkg::STATUS_DONE;
        if (rq.func == sjfba_pkg::FUNC_DISPATCH)
        begin
            found = 1'b0;
            best = 0;
            best_mean = '0;
            for (int i = 0; i < sjfba_pkg::DEF_NUM_SLOTS; i++)
            begin
                if (can_run[i] && (!found || avg_burst[i] < best_mean))
                begin
                    found = 1'b1;
                    best = i;
                    best_mean = avg_burst[i];
                end
            end
            if (!found)
            begin
                r.status = sjfba_pkg::STATUS_EMPTY;
                empty_count++;
            end
            else if (rq.now < pause_now && !shielded[best])
            begin
                r.status = sjfba_pkg::STATUS_PAUSED;
                paused_count++;
            end
            else
            begin
                can_run[best] = 1'b0;
                r.grant_valid = 1'b1;
                r.grant_slot = slot_t'(best);
                r.mean_value = best_mean;
                grant_count++;
            end
        end
        else
        begin
            case (rq.func)
                sjfba_pkg::FUNC_ALLOC:
                begin
                    shielded[rq.slot] = rq.prot;
                    avg_burst[rq.slot] = '0;
                    can_run[rq.slot] = 1'b0;
                end
                sjfba_pkg::FUNC_RUN:  can_run[rq.slot] = 1'b1;
                sjfba_pkg::FUNC_STOP: can_run[rq.slot] = 1'b0;
                sjfba_pkg::FUNC_BURST:
                begin
                    wt = (rate_now > sjfba_pkg::RATE_FULL) ? 32'(sjfba_pkg::RATE_FULL) :
                                                             32'(rate_now);
                    nm = ((32'(sjfba_pkg::DIVISOR) - wt) * 32'(avg_burst[rq.slot]) +
                          32'(rq.burst) * wt) / 32'(sjfba_pkg::DIVISOR);
                    avg_burst[rq.slot] = nm[sjfba_pkg::MEAN_FIELD-1:0];
                    r.mean_value = nm[sjfba_pkg::MEAN_FIELD-1:0];
                    burst_count++;
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    function automatic sched_req_t pick_request();
        sched_req_t  rq;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 14)
            rq.func = sjfba_pkg::FUNC_ALLOC;
        else if (pick < 40)
            rq.func = sjfba_pkg::FUNC_RUN;
        else if (pick < 50)
            rq.func = sjfba_pkg::FUNC_STOP;
        else if (pick < 75)
            rq.func = sjfba_pkg::FUNC_DISPATCH;
        else if (pick < 95)
            rq.func = sjfba_pkg::FUNC_BURST;
        else
            rq.func = func_t'($urandom_range(FUNC_UNKNOWN_HI, FUNC_UNKNOWN_LO));
        // half the traffic on a few slots so ties and reuse happen often
        if ($urandom_range(1) == 0)
            rq.slot = slot_t'($urandom_range(7));
        else
            rq.slot = slot_t'($urandom_range(sjfba_pkg::DEF_NUM_SLOTS - 1));
        rq.prot = 1'($urandom_range(1));
        case ($urandom_range(3))
            0:       rq.burst = '0;
            1:       rq.burst = BURST_MAX;
            2:       rq.burst = burst_t'($urandom_range(300));
            default: rq.burst = burst_t'($urandom);
        endcase
        case ($urandom_range(3))
            0:       rq.now = '0;
            1:       rq.now = TICK_MAX;
            2:       rq.now = tick_t'(pause_now + $urandom_range(2) - 1);
            default: rq.now = tick_t'($urandom);
        endcase
        return rq;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_request(input sched_req_t rq, input logic typed,
                                input sjfba_pkg::res_t typed_exp);
        sjfba_pkg::res_t predicted;
        while ($urandom_range(99) < src_idle)
        begin
            cmd.valid <= 1'b0;
            @(negedge clk);
        end
        cmd.valid          <= 1'b1;
        cmd.func           <= rq.func;
        cmd.slot           <= rq.slot;
        cmd.protected_flag <= rq.prot;
        cmd.burst_ticks    <= rq.burst;
        cmd.now_tick       <= rq.now;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        predicted = sched_outcome(rq);
        awaited_results.push_back(typed ? typed_exp : predicted);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic quiesce(input int cycles);
        cmd.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (cycles) @(negedge clk);
    endtask

    task automatic write_reg(input logic [sjfba_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [sjfba_pkg::CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == sjfba_pkg::CFG_RATE)
            rate_now = data[sjfba_pkg::RATE_BITS-1:0];
        else
            pause_now = data;
        @(negedge clk);
    endtask

    always @(negedge clk)
        take_result <= ($urandom_range(99) >= sink_idle);

    always @(posedge clk)
    begin
        sjfba_pkg::res_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result transfer with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (res.grant_valid !== want.grant_valid)
                begin
                    $error("grant_valid: expected %0d, got %0d", want.grant_valid,
                           res.grant_valid);
                    mismatches++;
                end
                if (res.grant_slot !== want.grant_slot)
                begin
                    $error("grant_slot: expected %0d, got %0d", want.grant_slot, res.grant_slot);
                    mismatches++;
                end
                if (res.mean_value !== want.mean_value)
                begin
                    $error("mean_value: expected %0d, got %0d", want.mean_value, res.mean_value);
                    mismatches++;
                end
                if (res.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, res.status);
                    mismatches++;
                end
            end
        end
    end

    // stall watchdog: counts cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (res.valid && res.ready))
            idle_cycles <= '0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("stalled for %0d cycles with %0d results outstanding",
                     idle_cycles, awaited_results.size());
            $display("sjf_burst_average_scheduler_core regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [sjfba_pkg::CFG_DATA_BITS-1:0] new_rate;
        logic [sjfba_pkg::CFG_DATA_BITS-1:0] new_pause;
        cmd.valid          = 1'b0;
        cmd.func           = sjfba_pkg::FUNC_ALLOC;
        cmd.slot           = '0;
        cmd.protected_flag = 1'b0;
        cmd.burst_ticks    = '0;
        cmd.now_tick       = '0;
        cfg_we             = 1'b0;
        cfg_index          = sjfba_pkg::CFG_RATE;
        cfg_data           = '0;
        for (int i = 0; i < sjfba_pkg::DEF_NUM_SLOTS; i++)
        begin
            can_run[i]   = 1'b0;
            shielded[i]  = 1'b0;
            avg_burst[i] = '0;
        end
        rate_now  = sjfba_pkg::RATE_RESET;
        pause_now = sjfba_pkg::PAUSE_RESET;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            case (DIRECTED[i].kind)
                ROW_RATE:
                begin
                    quiesce(SETTLE_CYCLES);
                    write_reg(sjfba_pkg::CFG_RATE, DIRECTED[i].req.now);
                end
                ROW_PAUSE:
                begin
                    quiesce(SETTLE_CYCLES);
                    write_reg(sjfba_pkg::CFG_PAUSE, DIRECTED[i].req.now);
                end
                ROW_CHECKED: send_request(DIRECTED[i].req, 1'b1, DIRECTED[i].exp);
                default:     send_request(DIRECTED[i].req, 1'b0, '0);
            endcase
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            quiesce(SETTLE_CYCLES);
            case (ph)
                0:
                begin
                    new_rate  = '0;
                    new_pause = '0;
                end
                1:
                begin
                    new_rate  = 32'(sjfba_pkg::RATE_FULL);
                    new_pause = TICK_MAX;
                end
                2:
                begin
                    new_rate  = '1;
                    new_pause = $urandom;
                end
                3:
                begin
                    new_rate  = $urandom_range(15);
                    new_pause = $urandom_range(1000);
                end
                4:
                begin
                    new_rate  = 32'(sjfba_pkg::RATE_RESET);
                    new_pause = '0;
                end
                default:
                begin
                    new_rate  = $urandom_range(15);
                    new_pause = $urandom;
                end
            endcase
            write_reg(sjfba_pkg::CFG_RATE, new_rate);
            write_reg(sjfba_pkg::CFG_PAUSE, new_pause);
            // receiver-heavy stalls, then sender-heavy, then full throughput
            case (ph / 2)
                0:
                begin
                    src_idle  = 20;
                    sink_idle = 70;
                end
                1:
                begin
                    src_idle  = 70;
                    sink_idle = 20;
                end
                default:
                begin
                    src_idle  = 0;
                    sink_idle = 0;
                end
            endcase
            repeat (ITEMS_PER_PHASE) send_request(pick_request(), 1'b0, '0);
        end

        quiesce(SETTLE_CYCLES);
        $display("%0d requests: %0d grants, %0d paused refusals, %0d empty dispatches,",
                 requests_sent, grant_count, paused_count, empty_count);
        $display("%0d mean updates; rate and pause limit swept across %0d settings",
                 burst_count, NUM_PHASES + 3);
        if (mismatches == 0 && awaited_results.size() == 0)
            $display("sjf_burst_average_scheduler_core regression: pass");
        else
            $display("sjf_burst_average_scheduler_core regression: fail");
        $finish;
    end
endmodule
